@@ hdl/ctp_pkg.sv @@
// Package: widths, codes and beat layout of the telemetry publisher.
package ctp_pkg;

   // Channel count and widths
   localparam int NUM_CH       = 3;
   localparam int CH_W         = 2;
   localparam int TIME_W       = 48;
   localparam int ID_W         = 16;
   localparam int VAL_W        = 32;
   localparam int GEN_W        = 32;
   localparam int PERIOD_W     = 32;
   localparam int CAP_W        = 2;
   localparam int CNT_W        = 2;

   // Snapshot period used when the register holds zero
   localparam logic [PERIOD_W-1:0] DEFAULT_SNAPSHOT_MS = PERIOD_W'(1000);

   // Beat widths
   localparam int REQ_TDATA_W  = 184;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 216;
   localparam int RSP_TUSER_W  = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   // Input operation codes
   typedef enum logic [1:0] {
      OP_UPD_POS  = 2'd0,
      OP_UPD_ATT  = 2'd1,
      OP_UPD_BATT = 2'd2,
      OP_POLL     = 2'd3
   } opcode_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_ACK      = 2'd0,
      KIND_DELTA    = 2'd1,
      KIND_SNAPSHOT = 2'd2
   } kind_type;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_SOURCE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_ADDRESS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SNAPSHOT_PERIOD = 2'd2;

endpackage

@@ hdl/change_triggered_telemetry_publisher_unit.sv @@
// Top level: change-triggered telemetry publisher with three channels.
// Latency: the first result beat of an item is presented the cycle after it is accepted.
// Throughput: an update yields one acknowledgement beat; a poll yields one beat per emitted
// message (up to three) or none, sent by the single result list at one beat a cycle while
// rsp_tready is high. A stalled result beat holds the list until it is taken.
// The next item is accepted in the cycle that the last beat of the current one is taken.
// Reset (synchronous, active high) clears valid, dirty, generations, timer and registers.
module change_triggered_telemetry_publisher_unit (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: now_ms, in_resource, in_source, in_value_a, in_value_b, in_value_c,
   //            out_capacity, zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ctp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: opcode
   input  logic [ctp_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // rsp_tdata: accepted, msg_type, msg_destination, msg_resource, msg_source,
   //            msg_value_a, msg_value_b, msg_value_c, msg_generation,
   //            msg_base_generation, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ctp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rsp_tuser: result_kind
   output logic [ctp_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ctp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ctp_pkg::*;

   // Configuration registers
   logic [ID_W-1:0]     own_source_ff;
   logic [ID_W-1:0]     dest_address_ff;
   logic [PERIOD_W-1:0] period_ff;

   // Channel state
   logic [NUM_CH-1:0]   valid_ff, valid_in;
   logic [NUM_CH-1:0]   dirty_ff, dirty_in;
   logic [GEN_W-1:0]    gen_ff   [NUM_CH];
   logic [GEN_W-1:0]    gen_in   [NUM_CH];
   logic [GEN_W-1:0]    base_ff  [NUM_CH];
   logic [ID_W-1:0]     res_ff   [NUM_CH];
   logic [ID_W-1:0]     src_ff   [NUM_CH];
   logic [VAL_W-1:0]    va_ff    [NUM_CH];
   logic [VAL_W-1:0]    vb_ff    [NUM_CH];
   logic [VAL_W-1:0]    vc_ff    [NUM_CH];
   logic [TIME_W-1:0]   next_ff, next_in;

   // Result list of the item being sent
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   kind_type            kind_ff, kind_in;
   logic                acc_ff, acc_in;
   logic [CH_W-1:0]     list_ff  [NUM_CH];
   logic [CH_W-1:0]     list_in  [NUM_CH];

   // Unpacked request fields
   opcode_type          op;
   logic [TIME_W-1:0]   now;
   logic [ID_W-1:0]     in_res;
   logic [ID_W-1:0]     in_src;
   logic [VAL_W-1:0]    in_va, in_vb, in_vc;
   logic [CAP_W-1:0]    cap;

   logic                req_beat, rsp_beat, rsp_last_beat;
   logic                is_upd, changed, due, store;
   logic [CH_W-1:0]     uch;
   logic [PERIOD_W-1:0] period;
   logic [TIME_W:0]     sum;
   logic [TIME_W-1:0]   time_next;
   logic [ID_W-1:0]     src_new;

   // Output selection
   logic [CH_W-1:0]     och;
   logic [ID_W-1:0]     o_res, o_src;
   logic [VAL_W-1:0]    o_va, o_vb, o_vc;
   logic [GEN_W-1:0]    o_gen, o_base;
   logic                o_ack;

   assign op     = opcode_type'(req_tuser);
   assign now    = req_tdata[47:0];
   assign in_res = req_tdata[63:48];
   assign in_src = req_tdata[79:64];
   assign in_va  = req_tdata[111:80];
   assign in_vb  = req_tdata[143:112];
   assign in_vc  = req_tdata[175:144];
   assign cap    = req_tdata[177:176];

   // Handshakes: take a new beat once the last result beat goes out
   assign rsp_tvalid    = (cnt_ff != '0);
   assign rsp_beat      = rsp_tvalid & rsp_tready;
   assign rsp_last_beat = rsp_beat & (pos_ff == cnt_ff - CNT_W'(1));
   assign req_tready    = (cnt_ff == '0) | rsp_last_beat;
   assign req_beat      = req_tvalid & req_tready;
   assign csr_ready     = 1'b1;

   // Timer arithmetic: now plus period, saturated to the time range
   assign period    = (period_ff == '0) ? DEFAULT_SNAPSHOT_MS : period_ff;
   assign sum       = {1'b0, now} + {{(TIME_W+1-PERIOD_W){1'b0}}, period};
   assign time_next = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   assign due       = (next_ff != '0) && (now >= next_ff);

   // Change detection for an update
   assign is_upd  = (op != OP_POLL);
   assign uch     = CH_W'(op);
   assign changed = !valid_ff[uch] || (res_ff[uch] != in_res) || (src_ff[uch] != in_src)
                    || (va_ff[uch] != in_va) || (vb_ff[uch] != in_vb)
                    || (vc_ff[uch] != in_vc);
   assign store   = req_beat && is_upd && changed;
   assign src_new = (in_src == '0) ? own_source_ff : in_src;

   // Next state of channels, timer and result list
   always_comb begin
      int unsigned k;
      logic        take;
      logic [CNT_W-1:0] n;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      gen_in   = gen_ff;
      next_in  = next_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      acc_in   = acc_ff;
      list_in  = list_ff;
      n        = '0;
      take     = 1'b0;

      // Advance or drain the result list
      if (rsp_last_beat) begin
         cnt_in = '0;
         pos_in = '0;
      end else if (rsp_beat) begin
         pos_in = pos_ff + CNT_W'(1);
      end

      if (req_beat) begin
         pos_in = '0;
         if (is_upd) begin
            kind_in    = KIND_ACK;
            acc_in     = changed;
            list_in[0] = uch;
            cnt_in     = CNT_W'(1);
            if (changed) begin
               valid_in[uch] = 1'b1;
               dirty_in[uch] = 1'b1;
               if (gen_ff[uch] != {GEN_W{1'b1}}) begin
                  gen_in[uch] = gen_ff[uch] + GEN_W'(1);
               end
               if (next_ff == '0) begin
                  next_in = time_next;
               end
            end
         end else if (cap != '0) begin
            acc_in  = 1'b0;
            kind_in = due ? KIND_SNAPSHOT : KIND_DELTA;
            for (k = 0; k < NUM_CH; k++) begin
               take = valid_ff[k] && (due || dirty_ff[k]) && (n < cap);
               if (take) begin
                  list_in[n] = CH_W'(k);
                  n          = n + CNT_W'(1);
               end
               if (due || take) begin
                  dirty_in[k] = 1'b0;
               end
            end
            cnt_in = n;
            if (due) begin
               next_in = time_next;
            end
         end else begin
            cnt_in = '0;
         end
      end
   end

   // Hold control state, configuration and result list
   always_ff @(posedge clock) begin
      if (reset) begin
         own_source_ff   <= '0;
         dest_address_ff <= '0;
         period_ff       <= '0;
         valid_ff        <= '0;
         dirty_ff        <= '0;
         next_ff         <= '0;
         cnt_ff          <= '0;
         pos_ff          <= '0;
         kind_ff         <= KIND_ACK;
         acc_ff          <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            gen_ff[i]  <= '0;
            list_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_OWN_SOURCE:      own_source_ff   <= csr_data[ID_W-1:0];
               CSR_DEST_ADDRESS:    dest_address_ff <= csr_data[ID_W-1:0];
               CSR_SNAPSHOT_PERIOD: period_ff       <= csr_data[PERIOD_W-1:0];
               default:             ;
            endcase
         end
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         gen_ff   <= gen_in;
         next_ff  <= next_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         acc_ff   <= acc_in;
         list_ff  <= list_in;
      end
   end

   // Store a changed record; base generation takes the previous generation
   always_ff @(posedge clock) begin
      if (store) begin
         res_ff[uch]  <= in_res;
         src_ff[uch]  <= src_new;
         va_ff[uch]   <= in_va;
         vb_ff[uch]   <= in_vb;
         vc_ff[uch]   <= in_vc;
         base_ff[uch] <= valid_ff[uch] ? gen_ff[uch] : '0;
      end
   end

   // Select the channel of the current beat; acknowledgements carry zeros
   assign och   = list_ff[pos_ff];
   assign o_ack = (kind_ff == KIND_ACK);
   assign o_res  = o_ack ? '0 : res_ff[och];
   assign o_src  = o_ack ? '0 : src_ff[och];
   assign o_va   = o_ack ? '0 : va_ff[och];
   assign o_vb   = o_ack ? '0 : vb_ff[och];
   assign o_vc   = o_ack ? '0 : vc_ff[och];
   assign o_gen  = o_ack ? '0 : gen_ff[och];
   assign o_base = (kind_ff == KIND_DELTA) ? base_ff[och] : '0;

   assign rsp_tdata = {5'b0, o_base, o_gen, o_vc, o_vb, o_va, o_src, o_res,
                       (o_ack ? {ID_W{1'b0}} : dest_address_ff), och, acc_ff};
   assign rsp_tuser = RSP_TUSER_W'(kind_ff);
   assign rsp_tlast = (pos_ff == cnt_ff - CNT_W'(1));

   // The beat position never runs past the list length
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pos_ff < cnt_ff))
      else $error("result position beyond list length");

   // An acknowledgement is a single beat
   a_ack_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && kind_ff == KIND_ACK) |-> (cnt_ff == CNT_W'(1) && rsp_tlast))
      else $error("acknowledgement is not a single last beat");

   // No new item is taken while earlier result beats still wait
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_last_beat) |-> !req_tready)
      else $error("request accepted while results pending");

   // A stored record leaves its channel valid and dirty
   a_store_marks: assert property (@(posedge clock) disable iff (reset)
      store |=> (valid_ff[$past(uch)] && dirty_ff[$past(uch)]))
      else $error("stored channel not marked valid and dirty");

endmodule

@@ verif/publisher_monitor.sv @@
// Checker for the telemetry publisher: mirrors its state, predicts result beats, compares them.
module publisher_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // req_tdata: now_ms, in_resource, in_source, in_value_a, in_value_b, in_value_c,
   //            out_capacity, zero pad
   input  logic [ctp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: opcode
   input  logic [ctp_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: accepted, msg_type, msg_destination, msg_resource, msg_source,
   //            msg_value_a, msg_value_b, msg_value_c, msg_generation,
   //            msg_base_generation, zero pad
   input  logic [ctp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rsp_tuser: result_kind
   input  logic [ctp_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                              rsp_tlast,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [ctp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctp_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                mismatches,
   output int                                owed_beats
);
   import ctp_pkg::*;

   typedef struct packed {
      kind_type           kind;
      logic               accepted;
      logic [CH_W-1:0]    chan;
      logic [ID_W-1:0]    dest;
      logic [ID_W-1:0]    resource;
      logic [ID_W-1:0]    source;
      logic [VAL_W-1:0]   va;
      logic [VAL_W-1:0]   vb;
      logic [VAL_W-1:0]   vc;
      logic [GEN_W-1:0]   gen;
      logic [GEN_W-1:0]   base;
      logic               last;
   } telemetry_beat_type;

   // Mirror of the channel store, timer and registers
   logic                ch_valid    [NUM_CH];
   logic                ch_dirty    [NUM_CH];
   logic [ID_W-1:0]     ch_resource [NUM_CH];
   logic [ID_W-1:0]     ch_source   [NUM_CH];
   logic [VAL_W-1:0]    ch_va       [NUM_CH];
   logic [VAL_W-1:0]    ch_vb       [NUM_CH];
   logic [VAL_W-1:0]    ch_vc       [NUM_CH];
   logic [GEN_W-1:0]    ch_gen      [NUM_CH];
   logic [GEN_W-1:0]    ch_base     [NUM_CH];
   logic [TIME_W-1:0]   snapshot_due_at;
   logic [ID_W-1:0]     cfg_own;
   logic [ID_W-1:0]     cfg_dest;
   logic [PERIOD_W-1:0] cfg_period;

   // Messages the block still owes, oldest first
   telemetry_beat_type owed_msgs[$];

   // Next snapshot time: now plus period, saturated at the largest time value
   function automatic logic [TIME_W-1:0] reschedule(input logic [TIME_W-1:0] t);
      logic [TIME_W:0]   sum;
      logic [TIME_W-1:0] step;
      step = (cfg_period == '0) ? TIME_W'(DEFAULT_SNAPSHOT_MS) : TIME_W'(cfg_period);
      sum = {1'b0, t} + {1'b0, step};
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   function automatic telemetry_beat_type message_of(input int ch, input kind_type k);
      telemetry_beat_type m;
      m = '0;
      m.kind     = k;
      m.chan     = CH_W'(ch);
      m.dest     = cfg_dest;
      m.resource = ch_resource[ch];
      m.source   = ch_source[ch];
      m.va       = ch_va[ch];
      m.vb       = ch_vb[ch];
      m.vc       = ch_vc[ch];
      m.gen      = ch_gen[ch];
      m.base     = (k == KIND_SNAPSHOT) ? '0 : ch_base[ch];
      return m;
   endfunction

   // Apply one accepted item to the mirror and queue the beats it causes
   task automatic take_request(input logic [REQ_TDATA_W-1:0] d,
                               input logic [REQ_TUSER_W-1:0] op_bits);
      opcode_type         op;
      logic [TIME_W-1:0]  now;
      logic [ID_W-1:0]    res;
      logic [ID_W-1:0]    src;
      logic [VAL_W-1:0]   a;
      logic [VAL_W-1:0]   b;
      logic [VAL_W-1:0]   c;
      int                 cap;
      int                 ch;
      logic               changed;
      logic               due;
      logic [GEN_W-1:0]   prev;
      telemetry_beat_type ack;
      telemetry_beat_type batch[$];
      op  = opcode_type'(op_bits);
      now = d[47:0];
      res = d[63:48];
      src = d[79:64];
      a   = d[111:80];
      b   = d[143:112];
      c   = d[175:144];
      cap = int'(d[177:176]);
      if (op != OP_POLL) begin
         ch = int'(op);
         changed = !ch_valid[ch] || ch_resource[ch] != res || ch_source[ch] != src ||
                   ch_va[ch] != a || ch_vb[ch] != b || ch_vc[ch] != c;
         if (changed) begin
            prev = ch_valid[ch] ? ch_gen[ch] : '0;
            ch_resource[ch] = res;
            ch_source[ch]   = (src == '0) ? cfg_own : src;
            ch_va[ch]       = a;
            ch_vb[ch]       = b;
            ch_vc[ch]       = c;
            ch_valid[ch]    = 1'b1;
            if (ch_gen[ch] != '1)
               ch_gen[ch] = ch_gen[ch] + GEN_W'(1);
            ch_base[ch]  = prev;
            ch_dirty[ch] = 1'b1;
            if (snapshot_due_at == '0)
               snapshot_due_at = reschedule(now);
         end
         // Acknowledge: only kind, accepted, channel and last are set
         ack          = '0;
         ack.kind     = KIND_ACK;
         ack.accepted = changed;
         ack.chan     = CH_W'(ch);
         ack.last     = 1'b1;
         owed_msgs.push_back(ack);
      end else if (cap != 0) begin
         due = (snapshot_due_at != '0) && (now >= snapshot_due_at);
         for (ch = 0; ch < NUM_CH; ch++) begin
            if (due) begin
               // Snapshot clears every dirty mark, emitted or not
               if (batch.size() < cap && ch_valid[ch])
                  batch.push_back(message_of(ch, KIND_SNAPSHOT));
               ch_dirty[ch] = 1'b0;
            end else if (ch_dirty[ch] && batch.size() < cap && ch_valid[ch]) begin
               batch.push_back(message_of(ch, KIND_DELTA));
               ch_dirty[ch] = 1'b0;
            end
         end
         if (due)
            snapshot_due_at = reschedule(now);
         if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
         foreach (batch[i])
            owed_msgs.push_back(batch[i]);
      end
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         if (mismatches < 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, seen);
         mismatches++;
      end
   endtask

   // Compare one result beat with the oldest owed message
   task automatic check_beat();
      telemetry_beat_type want;
      if (owed_msgs.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected result beat: kind %0d type %0d", rsp_tuser, rsp_tdata[2:1]);
         mismatches++;
      end else begin
         want = owed_msgs.pop_front();
         compare_field("result_kind",         32'(want.kind),     32'(rsp_tuser));
         compare_field("accepted",            32'(want.accepted), 32'(rsp_tdata[0]));
         compare_field("msg_type",            32'(want.chan),     32'(rsp_tdata[2:1]));
         compare_field("msg_destination",     32'(want.dest),     32'(rsp_tdata[18:3]));
         compare_field("msg_resource",        32'(want.resource), 32'(rsp_tdata[34:19]));
         compare_field("msg_source",          32'(want.source),   32'(rsp_tdata[50:35]));
         compare_field("msg_value_a",         want.va,            rsp_tdata[82:51]);
         compare_field("msg_value_b",         want.vb,            rsp_tdata[114:83]);
         compare_field("msg_value_c",         want.vc,            rsp_tdata[146:115]);
         compare_field("msg_generation",      want.gen,           rsp_tdata[178:147]);
         compare_field("msg_base_generation", want.base,          rsp_tdata[210:179]);
         compare_field("last",                32'(want.last),     32'(rsp_tlast));
      end
   endtask

   // Watch the three channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            ch_valid[i] = 1'b0;
            ch_dirty[i] = 1'b0;
            ch_gen[i]   = '0;
         end
         snapshot_due_at = '0;
         cfg_own         = '0;
         cfg_dest        = '0;
         cfg_period      = '0;
         owed_msgs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OWN_SOURCE:      cfg_own    = csr_data[ID_W-1:0];
               CSR_DEST_ADDRESS:    cfg_dest   = csr_data[ID_W-1:0];
               CSR_SNAPSHOT_PERIOD: cfg_period = csr_data[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready)
            check_beat();
         if (req_tvalid && req_tready)
            take_request(req_tdata, req_tuser);
      end
      owed_beats = owed_msgs.size();
   end

endmodule

@@ verif/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the telemetry publisher.
module testbench;
   import ctp_pkg::*;

   localparam int                CYCLE_LIMIT = 200000;
   localparam logic [TIME_W-1:0] TIME_MAX    = '1;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;
   logic [REQ_TUSER_W-1:0]   req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic [RSP_TUSER_W-1:0]   rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   int                       mismatches;
   int                       owed_beats;
   int                       cycles;
   int                       sender_idle;
   int                       receiver_idle;
   logic [TIME_W-1:0]        tnow;

   // Last update sent per channel, for repeats that must be rejected
   bit                       have_last [NUM_CH];
   logic [ID_W-1:0]          last_res  [NUM_CH];
   logic [ID_W-1:0]          last_src  [NUM_CH];
   logic [VAL_W-1:0]         last_a    [NUM_CH];
   logic [VAL_W-1:0]         last_b    [NUM_CH];
   logic [VAL_W-1:0]         last_c    [NUM_CH];

   change_triggered_telemetry_publisher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   publisher_monitor u_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .owed_beats (owed_beats)
   );

   always #2 clock = ~clock;

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Present one beat, idling beforehand at random; returns at the falling edge after acceptance
   task automatic send_item(input opcode_type op, input logic [TIME_W-1:0] now,
                            input logic [ID_W-1:0] res, input logic [ID_W-1:0] src,
                            input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                            input logic [VAL_W-1:0] c, input logic [CAP_W-1:0] cap);
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, cap, c, b, a, src, res, now};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_update(input int ch, input logic [TIME_W-1:0] now,
                              input logic [ID_W-1:0] res, input logic [ID_W-1:0] src,
                              input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                              input logic [VAL_W-1:0] c);
      have_last[ch] = 1'b1;
      last_res[ch]  = res;
      last_src[ch]  = src;
      last_a[ch]    = a;
      last_b[ch]    = b;
      last_c[ch]    = c;
      // Capacity is ignored on updates; send noise there
      send_item(opcode_type'(ch), now, res, src, a, b, c, CAP_W'($urandom_range(3)));
   endtask

   // Poll; the record fields are ignored, so fill them with noise
   task automatic send_poll(input logic [TIME_W-1:0] now, input logic [CAP_W-1:0] cap);
      send_item(OP_POLL, now, ID_W'($urandom), ID_W'($urandom), $urandom, $urandom,
                $urandom, cap);
   endtask

   // Hold the sender until every owed beat has arrived and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (owed_beats != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [ID_W-1:0] own, input logic [ID_W-1:0] dest,
                               input logic [PERIOD_W-1:0] period);
      write_reg(CSR_OWN_SOURCE, CSR_DATA_W'(own));
      write_reg(CSR_DEST_ADDRESS, CSR_DATA_W'(dest));
      write_reg(CSR_SNAPSHOT_PERIOD, period);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return ID_W'($urandom_range(1, 3));
         default: return ID_W'($urandom);
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'd1;
         2: return '1;
         3: return 32'h8000_0000;
         4: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Periods stay short so snapshots keep falling due on the running clock
   function automatic logic [PERIOD_W-1:0] pick_period();
      case ($urandom_range(3))
         0: return '0;
         1: return 32'd1;
         2: return PERIOD_W'($urandom_range(2, 200));
         default: return PERIOD_W'($urandom_range(2, 2000));
      endcase
   endfunction

   task automatic random_item();
      int                ch;
      logic [TIME_W-1:0] stamp;
      if ($urandom_range(99) < 55) begin
         ch = $urandom_range(NUM_CH - 1);
         // The timer is armed by now, so an update may carry any time at all
         stamp = ($urandom_range(99) < 30) ? {16'($urandom), 32'($urandom)} : tnow;
         if (have_last[ch] && $urandom_range(99) < 30)
            send_update(ch, stamp, last_res[ch], last_src[ch], last_a[ch], last_b[ch],
                        last_c[ch]);
         else
            send_update(ch, stamp, pick_id(), pick_id(), pick_value(), pick_value(),
                        pick_value());
      end else begin
         tnow = tnow + TIME_W'($urandom_range(0, 40));
         send_poll(tnow, ($urandom_range(9) == 0) ? CAP_W'(0) : CAP_W'($urandom_range(1, 3)));
      end
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_UPD_POS;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_OWN_SOURCE;
      csr_data      = '0;
      cycles        = 0;
      sender_idle   = 0;
      receiver_idle = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part
      program_regs(16'h1234, 16'hbeef, 32'd100);
      // nothing stored and the timer is not armed
      send_poll(48'd0, 2'd3);
      // first value arms the timer at 110
      send_update(0, 48'd10, 16'hffff, 16'h0000, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
      // source zero differs from the substituted own source, so it is taken again
      send_update(0, 48'd12, 16'hffff, 16'h0000, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
      // identical record: rejected
      send_update(0, 48'd14, 16'hffff, 16'h1234, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
      send_update(1, 48'd16, 16'h0000, 16'hffff, '1, '1, '1);
      send_update(2, 48'd18, 16'h0001, 16'h0001, 32'd0, 32'd0, 32'd0);
      // zero capacity does nothing although the timer is due
      send_poll(48'd200, 2'd0);
      send_poll(48'd50, 2'd1);
      send_poll(48'd60, 2'd3);
      send_poll(48'd70, 2'd3);
      send_update(0, 48'd80, 16'hffff, 16'h1234, 32'h8000_0000, 32'h7fff_ffff, 32'd5);
      send_update(1, 48'd85, 16'h0007, 16'hffff, '1, '1, '1);
      // due: two snapshots, battery cut by capacity, all dirty marks dropped
      send_poll(48'd110, 2'd2);
      send_poll(48'd111, 2'd3);
      send_update(2, 48'd120, 16'h0001, 16'h0001, 32'd0, 32'd0, 32'h7fff_ffff);
      send_poll(48'd300, 2'd3);
      send_poll(48'd301, 2'd3);
      tnow = 48'd400;

      // Random part in three idling phases, reprogrammed every 40 items
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle = 31; receiver_idle = 74; end
            1: begin sender_idle = 74; receiver_idle = 31; end
            default: begin sender_idle = 0; receiver_idle = 0; end
         endcase
         for (int n = 0; n < 150; n++) begin
            if (n % 40 == 0) begin
               drain();
               program_regs(pick_id(), pick_id(), pick_period());
            end
            random_item();
         end
      end

      // Saturating timer with the largest period, near the end of time
      drain();
      program_regs(pick_id(), pick_id(), '1);
      send_poll(TIME_MAX - 48'd50, 2'd3);
      send_update(1, {16'($urandom), 32'($urandom)}, pick_id(), pick_id(), pick_value(),
                  pick_value(), pick_value());
      send_poll(TIME_MAX - 48'd1, 2'd3);
      send_poll(TIME_MAX, 2'd3);
      send_poll(TIME_MAX, 2'd3);

      // Wind down
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (owed_beats != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
